[design/shfr_pkg.sv]
// shared types and constants for the sync-header frame receiver
// holds the hunt phase encoding, register map, config and frame structs
// no dependencies
package shfr_pkg;

   // register map, index = byte address / 4
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_SYNC_FIRST  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SYNC_SECOND = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SYNC_THIRD  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ID_LOWEST   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ID_HIGHEST  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_WANTED_ID   = 3'd5;

   // register reset values
   localparam logic [7:0] RST_SYNC_FIRST  = 8'hFF;
   localparam logic [7:0] RST_SYNC_SECOND = 8'hFF;
   localparam logic [7:0] RST_SYNC_THIRD  = 8'hA1;
   localparam logic [7:0] RST_ID_LOWEST   = 8'h00;
   localparam logic [7:0] RST_ID_HIGHEST  = 8'hFF;
   localparam logic [7:0] RST_WANTED_ID   = 8'h00;

   // accepted range of the length byte
   localparam logic [7:0] LEN_MIN = 8'd3;
   localparam logic [7:0] LEN_MAX = 8'd5;

   // payload bytes taken before the checksum byte
   localparam logic [1:0] SEEN_FIRST  = 2'd0;
   localparam logic [1:0] SEEN_SECOND = 2'd1;
   localparam logic [1:0] SEEN_CHECK  = 2'd2;

   localparam int RSP_DATA_W = 40;

   typedef enum logic [5:0] {
      PH_HEAD1   = 6'b000001,
      PH_HEAD2   = 6'b000010,
      PH_HEAD3   = 6'b000100,
      PH_ID      = 6'b001000,
      PH_LEN     = 6'b010000,
      PH_PAYLOAD = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0] wanted_id;
      logic [7:0] id_highest;
      logic [7:0] id_lowest;
      logic [7:0] sync_third;
      logic [7:0] sync_second;
      logic [7:0] sync_first;
   } cfg_type;

   // last member sits in the lowest bits
   typedef struct packed {
      logic [7:0] frame_check;
      logic [7:0] payload_second;
      logic [7:0] payload_first;
      logic [2:0] length_field;
      logic [7:0] device_id;
   } frame_type;

   localparam int FRAME_W = $bits(frame_type);

endpackage

[design/shfr_csr.sv]
// configuration register file of the frame receiver, apb-style slave
// depends on shfr_pkg for the register map and cfg_type
module shfr_csr
   import shfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic [7:0]           wr_byte;
   logic [7:0]           rd_byte;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_byte    = csr_pwdata[7:0];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // write decode, unknown indexes leave everything alone
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SYNC_FIRST:  cfg_in.sync_first  = wr_byte;
            REG_SYNC_SECOND: cfg_in.sync_second = wr_byte;
            REG_SYNC_THIRD:  cfg_in.sync_third  = wr_byte;
            REG_ID_LOWEST:   cfg_in.id_lowest   = wr_byte;
            REG_ID_HIGHEST:  cfg_in.id_highest  = wr_byte;
            REG_WANTED_ID:   cfg_in.wanted_id   = wr_byte;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= RST_SYNC_FIRST;
         cfg_ff.sync_second <= RST_SYNC_SECOND;
         cfg_ff.sync_third  <= RST_SYNC_THIRD;
         cfg_ff.id_lowest   <= RST_ID_LOWEST;
         cfg_ff.id_highest  <= RST_ID_HIGHEST;
         cfg_ff.wanted_id   <= RST_WANTED_ID;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read decode
   always_comb begin
      unique case (reg_idx)
         REG_SYNC_FIRST:  rd_byte = cfg_ff.sync_first;
         REG_SYNC_SECOND: rd_byte = cfg_ff.sync_second;
         REG_SYNC_THIRD:  rd_byte = cfg_ff.sync_third;
         REG_ID_LOWEST:   rd_byte = cfg_ff.id_lowest;
         REG_ID_HIGHEST:  rd_byte = cfg_ff.id_highest;
         REG_WANTED_ID:   rd_byte = cfg_ff.wanted_id;
         default:         rd_byte = 8'h00;
      endcase
   end

   assign csr_prdata = {{(CSR_DATA_W-8){1'b0}}, rd_byte};
   assign cfg        = cfg_ff;

endmodule

[design/shfr_parser.sv]
// header hunt state machine with running checksum and frame capture
// depends on shfr_pkg for phase_type, cfg_type and frame_type
module shfr_parser
   import shfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic [7:0] rx_byte,
   input  logic       fire,
   output logic       emit,
   output frame_type  frame
);

   phase_type  phase_ff, phase_in;
   logic [1:0] seen_ff, seen_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] id_ff, id_in;
   logic [2:0] len_ff, len_in;
   logic [7:0] pay0_ff, pay0_in;
   logic [7:0] pay1_ff, pay1_in;
   logic [7:0] sum_add;

   assign sum_add = sum_ff + rx_byte;

   // next state of the hunt for the byte at the head of the pipe
   always_comb begin
      phase_in = phase_ff;
      seen_in  = seen_ff;
      sum_in   = sum_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      pay0_in  = pay0_ff;
      pay1_in  = pay1_ff;
      emit     = 1'b0;
      unique case (phase_ff)
         PH_HEAD2: begin
            if (rx_byte == cfg.sync_second) begin
               phase_in = PH_HEAD3;
            end else if (rx_byte != cfg.sync_first) begin
               phase_in = PH_HEAD1;
               seen_in  = SEEN_FIRST;
            end
         end
         PH_HEAD3: begin
            if (rx_byte == cfg.sync_third) begin
               sum_in   = rx_byte;
               phase_in = PH_ID;
            end else begin
               phase_in = PH_HEAD1;
               seen_in  = SEEN_FIRST;
            end
         end
         PH_ID: begin
            if (rx_byte >= cfg.id_lowest && rx_byte <= cfg.id_highest) begin
               id_in    = rx_byte;
               sum_in   = sum_add;
               phase_in = PH_LEN;
            end else begin
               phase_in = PH_HEAD1;
               seen_in  = SEEN_FIRST;
            end
         end
         PH_LEN: begin
            len_in = rx_byte[2:0];
            if (rx_byte >= LEN_MIN && rx_byte <= LEN_MAX) begin
               sum_in   = sum_add;
               seen_in  = SEEN_FIRST;
               phase_in = PH_PAYLOAD;
            end else begin
               phase_in = PH_HEAD1;
               seen_in  = SEEN_FIRST;
            end
         end
         PH_PAYLOAD: begin
            if (seen_ff == SEEN_FIRST) begin
               pay0_in = rx_byte;
               sum_in  = sum_add;
               seen_in = SEEN_SECOND;
            end else if (seen_ff == SEEN_SECOND) begin
               pay1_in = rx_byte;
               sum_in  = sum_add;
               seen_in = SEEN_CHECK;
            end else begin
               // checksum byte closes the frame either way
               emit     = (~sum_ff == rx_byte) && (id_ff == cfg.wanted_id);
               phase_in = PH_HEAD1;
               seen_in  = SEEN_FIRST;
            end
         end
         default: begin
            // wait for first header, stray codes land here too
            phase_in = (rx_byte == cfg.sync_first) ? PH_HEAD2 : PH_HEAD1;
            seen_in  = SEEN_FIRST;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD1;
         seen_ff  <= SEEN_FIRST;
      end else if (fire) begin
         phase_ff <= phase_in;
         seen_ff  <= seen_in;
      end
   end

   // frame fields and running sum
   always_ff @(posedge clock) begin
      if (fire) begin
         sum_ff  <= sum_in;
         id_ff   <= id_in;
         len_ff  <= len_in;
         pay0_ff <= pay0_in;
         pay1_ff <= pay1_in;
      end
   end

   assign frame.device_id      = id_ff;
   assign frame.length_field   = len_ff;
   assign frame.payload_first  = pay0_ff;
   assign frame.payload_second = pay1_ff;
   assign frame.frame_check    = rx_byte;

   // a frame only closes on the checksum byte
   a_emit_on_check: assert property (@(posedge clock) disable iff (reset)
      emit |-> (phase_ff == PH_PAYLOAD) && (seen_ff == SEEN_CHECK))
      else $error("frame emitted outside the checksum byte");

   // the checksum byte always restarts the hunt
   a_check_restarts: assert property (@(posedge clock) disable iff (reset)
      fire && (phase_ff == PH_PAYLOAD) && (seen_ff == SEEN_CHECK)
      |=> (phase_ff == PH_HEAD1) && (seen_ff == SEEN_FIRST))
      else $error("hunt did not restart after checksum byte");

   // payload count only moves while collecting payload
   a_seen_scope: assert property (@(posedge clock) disable iff (reset)
      (seen_ff != SEEN_FIRST) |-> (phase_ff == PH_PAYLOAD) &&
      (seen_ff == SEEN_SECOND || seen_ff == SEEN_CHECK))
      else $error("payload count out of its phase");

endmodule

[design/sync_header_frame_receiver.sv]
// sync-header frame receiver: the beat that brings a frame's checksum byte
// passes the input register, one pass through the hunt logic and the result
// register, which raises rsp_tvalid; one byte is taken every cycle unless it closes a
// frame and meets a full slot; a held result does not stall bytes that close no frame
// reset (synchronous) empties both registers, restarts the hunt and loads
// the register defaults; no clearing pass is needed
module sync_header_frame_receiver
   import shfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] rx_byte
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] device_id, [10:8] length_field,
                                              // [18:11] payload_first,
                                              // [26:19] payload_second,
                                              // [34:27] frame_check, rest zero
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   frame_type  frame;
   frame_type  rsp_frame_ff;
   logic       emit;
   logic       advance;
   logic       out_free;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   shfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   shfr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .rx_byte (in_byte_ff),
      .fire    (advance),
      .emit    (emit),
      .frame   (frame)
   );

   // a byte moves on unless it closes a frame and the result slot is taken
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!emit || out_free);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign rsp_valid_in = (advance && emit) || (rsp_valid_ff && !rsp_tready);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_frame_ff <= frame;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-FRAME_W){1'b0}}, rsp_frame_ff};

   // a closed frame shows up on the result side next cycle
   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      advance && emit |=> rsp_valid_ff)
      else $error("emitted frame did not reach the result register");

   // a waiting byte that closes a frame is held while the slot is full
   a_hold_on_full: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && emit && !out_free |-> !advance && !req_tready)
      else $error("frame byte advanced into a full result slot");

   // results never overwritten before the beat
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(rsp_frame_ff))
      else $error("pending result changed before it was taken");

endmodule

[dv/sync_header_frame_receiver_tb.sv]
// self-checking bench for the sync-header frame receiver: directed table, then
// random frames under several register settings, scored by table tags or an in-bench model
// depends on shfr_pkg and the sync_header_frame_receiver rtl
module sync_header_frame_receiver_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import shfr_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int IDLE_PCT     = 27;
   localparam int DRAIN_CYCLES = 6;
   localparam int PHASE_BYTES  = 200;
   localparam int REPORT_LIMIT = 10;

   // indexes past the register map
   localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   // register settings the random part walks through
   typedef enum int {
      SET_RESET,
      SET_ZEROS,
      SET_ONES,
      SET_SPLIT_HEADERS,
      SET_ID_MISSED,
      SET_NO_IDLE,
      SET_SAME_HEADERS,
      SET_DEFAULTS,
      SET_COUNT
   } setting_type;

   localparam cfg_type RESET_CFG = '{wanted_id: RST_WANTED_ID, id_highest: RST_ID_HIGHEST,
                                     id_lowest: RST_ID_LOWEST, sync_third: RST_SYNC_THIRD,
                                     sync_second: RST_SYNC_SECOND,
                                     sync_first: RST_SYNC_FIRST};

   localparam frame_type NO_FRAME   = '0;
   localparam frame_type EDGE_FRAME = '{frame_check: 8'h5B, payload_second: 8'hFF,
                                        payload_first: 8'hFF, length_field: 3'd5,
                                        device_id: 8'h00};

   // one directed beat; fixed rows carry their expectation, the rest use the model
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       fixed;
      logic       yields;
      frame_type  frame;
   } dir_row_type;

   localparam int DIR_ROWS = 24;
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      // widest frame under reset headers: length 5, both payload bytes all ones
      '{8'hFF, 1'b1, 1'b0, NO_FRAME},
      '{8'hFF, 1'b1, 1'b0, NO_FRAME},
      '{8'hA1, 1'b1, 1'b0, NO_FRAME},
      '{8'h00, 1'b1, 1'b0, NO_FRAME},
      '{8'h05, 1'b1, 1'b0, NO_FRAME},
      '{8'hFF, 1'b1, 1'b0, NO_FRAME},
      '{8'hFF, 1'b1, 1'b0, NO_FRAME},
      '{8'h5B, 1'b1, 1'b1, EDGE_FRAME},
      // length byte above the range drops the frame
      '{8'hFF, 1'b1, 1'b0, NO_FRAME},
      '{8'hFF, 1'b1, 1'b0, NO_FRAME},
      '{8'hA1, 1'b1, 1'b0, NO_FRAME},
      '{8'h00, 1'b1, 1'b0, NO_FRAME},
      '{8'h06, 1'b1, 1'b0, NO_FRAME},
      // third header wrong, the breaking byte is not taken as a new header
      '{8'hFF, 1'b0, 1'b0, NO_FRAME},
      '{8'hFF, 1'b0, 1'b0, NO_FRAME},
      '{8'hFF, 1'b0, 1'b0, NO_FRAME},
      // good checksum but id 0x07 is not the wanted one
      '{8'hFF, 1'b0, 1'b0, NO_FRAME},
      '{8'hFF, 1'b0, 1'b0, NO_FRAME},
      '{8'hA1, 1'b0, 1'b0, NO_FRAME},
      '{8'h07, 1'b0, 1'b0, NO_FRAME},
      '{8'h03, 1'b0, 1'b0, NO_FRAME},
      '{8'h10, 1'b0, 1'b0, NO_FRAME},
      '{8'h20, 1'b0, 1'b0, NO_FRAME},
      '{8'h24, 1'b0, 1'b0, NO_FRAME}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;    // [7:0] rx_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;    // [7:0] device_id, [10:8] length_field,
                                        // [18:11] payload_first, [26:19] payload_second,
                                        // [34:27] frame_check, rest zero
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // tags of the beat on the bus
   logic      beat_fixed;
   logic      beat_yields;
   frame_type beat_frame;

   // model copy of registers and hunt state
   cfg_type    cfg;
   phase_type  hunt;
   logic [7:0] held_id_q;
   logic [7:0] held_len_q;
   logic [7:0] held_pay [2];
   logic [7:0] check_sum;
   logic [1:0] pay_count;

   frame_type             frames_due [$];
   logic [CSR_DATA_W-1:0] csr_rdata_seen;
   logic                  idle_on = 1'b1;
   int                    rx_beats;
   int                    csr_beats;
   int                    frames_seen;
   int                    reg_reads;
   int                    settings_run;
   int                    mismatches;

   sync_header_frame_receiver DUT (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   // result side back-pressure
   always @(negedge clock) begin
      rsp_tready = idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
   end

   function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] seen);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s expected %0h got %0h", $time, what, want, seen);
   endfunction

   function automatic void drop_frame();
      hunt = PH_HEAD1;
      pay_count = SEEN_FIRST;
   endfunction

   // one step of the header hunt, returns 1 when the byte closes a deliverable frame
   function automatic logic hunt_frame(input logic [7:0] rx, output frame_type got);
      logic hit;
      hit = 1'b0;
      got = NO_FRAME;
      case (hunt)
         PH_HEAD2: begin
            // second header is tested first, a repeated first header holds here
            if (rx == cfg.sync_second)
               hunt = PH_HEAD3;
            else if (rx != cfg.sync_first)
               drop_frame();
         end
         PH_HEAD3: begin
            if (rx == cfg.sync_third) begin
               check_sum = rx;
               hunt = PH_ID;
            end else begin
               drop_frame();
            end
         end
         PH_ID: begin
            if (rx >= cfg.id_lowest && rx <= cfg.id_highest) begin
               held_id_q = rx;
               check_sum = check_sum + rx;
               hunt = PH_LEN;
            end else begin
               drop_frame();
            end
         end
         PH_LEN: begin
            held_len_q = rx;
            if (rx >= LEN_MIN && rx <= LEN_MAX) begin
               check_sum = check_sum + rx;
               pay_count = SEEN_FIRST;
               hunt = PH_PAYLOAD;
            end else begin
               drop_frame();
            end
         end
         PH_PAYLOAD: begin
            // always three payload bytes, the last one is the checksum
            if (pay_count != SEEN_CHECK) begin
               held_pay[pay_count[0]] = rx;
               check_sum = check_sum + rx;
               pay_count = pay_count + 2'd1;
            end else begin
               if (rx == ~check_sum && held_id_q == cfg.wanted_id) begin
                  hit = 1'b1;
                  got.device_id = held_id_q;
                  got.length_field = held_len_q[2:0];
                  got.payload_first = held_pay[0];
                  got.payload_second = held_pay[1];
                  got.frame_check = rx;
               end
               drop_frame();
            end
         end
         default: begin
            if (rx == cfg.sync_first)
               hunt = PH_HEAD2;
            else
               hunt = PH_HEAD1;
            pay_count = SEEN_FIRST;
         end
      endcase
      return hit;
   endfunction

   // score every beat at the rising edge
   always @(posedge clock) begin : score
      frame_type found;
      frame_type due;
      frame_type got;
      logic      hit;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pready) begin
            csr_beats++;
            csr_rdata_seen = csr_prdata;
         end
         if (req_tvalid && req_tready) begin
            rx_beats++;
            hit = hunt_frame(req_tdata, found);
            if (beat_fixed) begin
               if (beat_yields)
                  frames_due.push_back(beat_frame);
            end else if (hit) begin
               frames_due.push_back(found);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            frames_seen++;
            got = frame_type'(rsp_tdata[FRAME_W-1:0]);
            if (frames_due.size() == 0) begin
               note_mismatch("frame with none due", '0, 64'(rsp_tdata));
            end else begin
               due = frames_due.pop_front();
               if (got.device_id !== due.device_id)
                  note_mismatch("device_id", 64'(due.device_id), 64'(got.device_id));
               if (got.length_field !== due.length_field)
                  note_mismatch("length_field", 64'(due.length_field),
                                64'(got.length_field));
               if (got.payload_first !== due.payload_first)
                  note_mismatch("payload_first", 64'(due.payload_first),
                                64'(got.payload_first));
               if (got.payload_second !== due.payload_second)
                  note_mismatch("payload_second", 64'(due.payload_second),
                                64'(got.payload_second));
               if (got.frame_check !== due.frame_check)
                  note_mismatch("frame_check", 64'(due.frame_check), 64'(got.frame_check));
               if (rsp_tdata[RSP_DATA_W-1:FRAME_W] !== '0)
                  note_mismatch("tdata padding", '0, 64'(rsp_tdata[RSP_DATA_W-1:FRAME_W]));
            end
         end
      end
   end

   // all tasks below start and end at a falling edge

   task automatic send_byte(input logic [7:0] rx, input logic fixed = 1'b0,
                            input logic yields = 1'b0, input frame_type fr = NO_FRAME);
      int target;
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = rx;
      beat_fixed = fixed;
      beat_yields = yields;
      beat_frame = fr;
      target = rx_beats + 1;
      do @(negedge clock); while (rx_beats != target);
   endtask

   task automatic csr_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      int target;
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = wr;
      csr_paddr = CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      target = csr_beats + 1;
      do @(negedge clock); while (csr_beats != target);
      rdata = csr_rdata_seen;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] val);
      logic [CSR_DATA_W-1:0] ignored;
      csr_access(1'b1, idx, CSR_DATA_W'(val), ignored);
      // cfg_type lays the registers out in index order from the low byte up
      if (idx <= REG_WANTED_ID)
         cfg[idx*8 +: 8] = val;
   endtask

   task automatic check_regs();
      logic [CSR_DATA_W-1:0] rd;
      for (int i = REG_SYNC_FIRST; i <= REG_WANTED_ID; i++) begin
         csr_access(1'b0, REG_IDX_W'(i), '0, rd);
         reg_reads++;
         if (rd !== CSR_DATA_W'(cfg[i*8 +: 8]))
            note_mismatch("register read", 64'(cfg[i*8 +: 8]), 64'(rd));
      end
   endtask

   task automatic apply_settings(input cfg_type c);
      for (int i = REG_SYNC_FIRST; i <= REG_WANTED_ID; i++)
         write_reg(REG_IDX_W'(i), c[i*8 +: 8]);
      // writes past the map must leave every register alone
      write_reg(REG_SPARE_LO, 8'($urandom));
      write_reg(REG_SPARE_HI, 8'($urandom));
   endtask

   // wait out every due frame and the pipeline behind it
   task automatic settle();
      req_tvalid = 1'b0;
      while (frames_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic cfg_type pick_settings(input setting_type kind);
      cfg_type c;
      c.sync_first = 8'($urandom);
      c.sync_second = c.sync_first ^ 8'($urandom_range(255, 1));
      c.sync_third = 8'($urandom);
      c.id_lowest = 8'($urandom);
      c.id_highest = 8'($urandom_range(255, c.id_lowest));
      c.wanted_id = 8'($urandom_range(c.id_highest, c.id_lowest));
      case (kind)
         SET_ZEROS: c = '{wanted_id: 8'h00, id_highest: 8'hFF, id_lowest: 8'h00,
                          sync_third: 8'h00, sync_second: 8'h00, sync_first: 8'h00};
         SET_ONES: c = '{wanted_id: 8'hFF, id_highest: 8'hFF, id_lowest: 8'hFF,
                         sync_third: 8'hFF, sync_second: 8'hFF, sync_first: 8'hFF};
         SET_ID_MISSED: begin
            // wanted id below the accepted range, nothing can be delivered
            c.id_lowest = 8'($urandom_range(255, 1));
            c.id_highest = 8'($urandom_range(255, c.id_lowest));
            c.wanted_id = 8'($urandom_range(c.id_lowest - 1, 0));
         end
         SET_SAME_HEADERS: c.sync_second = c.sync_first;
         SET_DEFAULTS: c = RESET_CFG;
         default: ;
      endcase
      return c;
   endfunction

   // frame with random content, mostly well-formed, or one cut short by a stray byte
   task automatic send_frame(input logic broken);
      logic [7:0] seq [$];
      logic [7:0] id;
      logic [7:0] len;
      logic [7:0] p1;
      logic [7:0] p2;
      logic [7:0] sum;
      int         cut;
      seq.push_back(cfg.sync_first);
      if (cfg.sync_first != cfg.sync_second)
         repeat ($urandom_range(2)) seq.push_back(cfg.sync_first);
      seq.push_back(cfg.sync_second);
      seq.push_back(cfg.sync_third);
      id = ($urandom_range(99) < 75) ? cfg.wanted_id : 8'($urandom);
      len = ($urandom_range(99) < 90) ? 8'($urandom_range(LEN_MAX, LEN_MIN)) : 8'($urandom);
      p1 = 8'($urandom);
      p2 = 8'($urandom);
      sum = cfg.sync_third + id + len + p1 + p2;
      seq.push_back(id);
      seq.push_back(len);
      seq.push_back(p1);
      seq.push_back(p2);
      seq.push_back(($urandom_range(99) < 85) ? ~sum : 8'($urandom));
      if (broken) begin
         cut = $urandom_range(seq.size() - 1, 1);
         while (seq.size() > cut) void'(seq.pop_back());
         seq.push_back(8'($urandom));
      end
      foreach (seq[k])
         send_byte(seq[k]);
   endtask

   task automatic run_phase(input setting_type kind);
      int stop_at;
      int roll;
      settle();
      if (kind != SET_RESET)
         apply_settings(pick_settings(kind));
      check_regs();
      idle_on = (kind != SET_NO_IDLE);
      stop_at = rx_beats + PHASE_BYTES;
      while (rx_beats < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 75)
            send_frame(1'b0);
         else if (roll < 87)
            send_frame(1'b1);
         else
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
      end
      settings_run++;
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      beat_fixed = 1'b0;
      beat_yields = 1'b0;
      beat_frame = NO_FRAME;
      cfg = RESET_CFG;
      hunt = PH_HEAD1;
      held_id_q = '0;
      held_len_q = '0;
      held_pay[0] = '0;
      held_pay[1] = '0;
      check_sum = '0;
      pay_count = SEEN_FIRST;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // reset values, then the directed table
      check_regs();
      foreach (DIR_TABLE[r])
         send_byte(DIR_TABLE[r].rx_byte, DIR_TABLE[r].fixed, DIR_TABLE[r].yields,
                   DIR_TABLE[r].frame);

      for (int ph = SET_RESET; ph < SET_COUNT; ph++)
         run_phase(setting_type'(ph));
      settle();

      $display("fed %0d bytes across %0d register settings, one with no idling at all",
               rx_beats, settings_run);
      $display("compared %0d delivered frames and %0d register reads", frames_seen,
               reg_reads);
      if (mismatches == 0 && frames_due.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Mismatches found");
      $finish;
   end

endmodule
